@@ design/sspk_pkg.sv @@
package sspk_pkg;

  localparam int unsigned FREQ_W  = 30;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned READ_W  = 16;

  typedef logic [FREQ_W-1:0]          freq_t;
  typedef logic signed [LEVEL_W-1:0]  level_t;
  typedef logic signed [READ_W-1:0]   reading_t;
  typedef logic [5:0]                 bin_out_t;

  typedef enum logic [1:0] {
    CFG_SPAN_START  = 2'd0,
    CFG_SPAN_STOP   = 2'd1,
    CFG_LEVEL_FLOOR = 2'd2,
    CFG_LEVEL_CEIL  = 2'd3
  } cfg_idx_e;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam freq_t  SPAN_START_RST  = 30'd433050000;
  localparam freq_t  SPAN_STOP_RST   = 30'd434790000;
  localparam level_t LEVEL_FLOOR_RST = -8'sd120;
  localparam level_t LEVEL_CEIL_RST  = -8'sd20;

  localparam logic [1:0] HOLD_CYCLES = 2'd3;

endpackage

@@ design/spectrum_sweep_peak_hold_unit.sv @@
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_ready_o   kind_i, reading_dbm_i
// out       out        out_valid_o / out_ready_i bin_index_o .. best_freq_hz_o
//
// One input transfer is taken per cycle unless the output stalls or a hold is pending;
// its result passes stages s1 to s5 and the output register before it is offered.
// The bin frequencies come from a span quotient that a three-stage divider rebuilds
// from the span registers, so the input is held off after reset and after every
// configuration write until hold_q runs down. The configuration port is always ready.
// Pipeline stages advance independently, so a stalled output fills the empty stages
// before the input stops.
module spectrum_sweep_peak_hold_unit #(
  parameter int unsigned NUM_BINS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [29:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  sspk_pkg::reading_t   reading_dbm_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sspk_pkg::bin_out_t   bin_index_o,
  output sspk_pkg::level_t     level_o,
  output sspk_pkg::level_t     peak_level_o,
  output sspk_pkg::freq_t      tune_freq_hz_o,
  output logic                 sweep_end_o,
  output sspk_pkg::bin_out_t   best_bin_o,
  output sspk_pkg::level_t     best_level_o,
  output sspk_pkg::freq_t      best_freq_hz_o
);

  localparam int unsigned BIN_W = $clog2(NUM_BINS);
  localparam int unsigned NSTG = 5;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    sspk_pkg::level_t level;
    sspk_pkg::level_t peak;
    logic             sweep_end;
    logic [BIN_W-1:0] best_bin;
    sspk_pkg::level_t best_level;
  } item_t;

  sspk_pkg::freq_t  start_q;
  sspk_pkg::freq_t  stop_q;
  sspk_pkg::level_t floor_q;
  sspk_pkg::level_t ceil_q;
  logic [1:0]       hold_q;

  logic [NSTG-1:0] stg_vld_q;
  logic [NSTG-1:0] stg_vld_d;
  logic [NSTG-1:0] rdy;
  logic            out_rdy;
  logic            out_valid_q;
  logic            accept;
  logic            cfg_we;

  item_t            s1_item;
  logic [BIN_W-1:0] s1_tune;
  item_t            s2_q;
  logic [BIN_W-1:0] s2_tune_q;
  item_t            s3_q;
  item_t            s4_q;
  item_t            s5_q;
  item_t            out_q;
  sspk_pkg::freq_t  tune_f;
  sspk_pkg::freq_t  best_f;
  sspk_pkg::freq_t  tune_f_q;
  sspk_pkg::freq_t  best_f_q;

  sspk_pkg::freq_t  quot;
  logic [BIN_W-1:0] rem;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= sspk_pkg::SPAN_START_RST;
      stop_q  <= sspk_pkg::SPAN_STOP_RST;
      floor_q <= sspk_pkg::LEVEL_FLOOR_RST;
      ceil_q  <= sspk_pkg::LEVEL_CEIL_RST;
      hold_q  <= sspk_pkg::HOLD_CYCLES;
    end else begin
      if (cfg_we) begin
        hold_q <= sspk_pkg::HOLD_CYCLES;
        case (sspk_pkg::cfg_idx_e'(cfg_index_i))
          sspk_pkg::CFG_SPAN_START:  start_q <= cfg_data_i;
          sspk_pkg::CFG_SPAN_STOP:   stop_q  <= cfg_data_i;
          sspk_pkg::CFG_LEVEL_FLOOR: floor_q <= sspk_pkg::level_t'(cfg_data_i[7:0]);
          sspk_pkg::CFG_LEVEL_CEIL:  ceil_q  <= sspk_pkg::level_t'(cfg_data_i[7:0]);
          default: ;
        endcase
      end else if (hold_q != '0) begin
        hold_q <= hold_q - 1'b1;
      end
    end
  end

  always_comb begin
    out_rdy = !out_valid_q || out_ready_i;
    rdy[NSTG-1] = !stg_vld_q[NSTG-1] || out_rdy;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !stg_vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0] && (hold_q == '0);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      if (rdy[k]) begin
        stg_vld_d[k] = (k == 0) ? accept : stg_vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        stg_vld_d[k] = stg_vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      stg_vld_q <= stg_vld_d;
      if (out_rdy) begin
        out_valid_q <= stg_vld_q[NSTG-1];
      end
    end
  end

  sspk_peak #(
    .NUM_BINS (NUM_BINS)
  ) u_peak (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .kind_i        (kind_i),
    .reading_dbm_i (reading_dbm_i),
    .fire_i        (stg_vld_q[0] && rdy[1]),
    .level_floor_i (floor_q),
    .level_ceil_i  (ceil_q),
    .bin_o         (s1_item.bin),
    .level_o       (s1_item.level),
    .peak_o        (s1_item.peak),
    .sweep_end_o   (s1_item.sweep_end),
    .best_bin_o    (s1_item.best_bin),
    .best_level_o  (s1_item.best_level),
    .tune_bin_o    (s1_tune)
  );

  sspk_span_div #(
    .NUM_BINS (NUM_BINS)
  ) u_span_div (
    .clk_i   (clk_i),
    .start_i (start_q),
    .stop_i  (stop_q),
    .quot_o  (quot),
    .rem_o   (rem)
  );

  sspk_freq #(
    .NUM_BINS (NUM_BINS)
  ) u_tune_freq (
    .clk_i   (clk_i),
    .en_i    (rdy[4:2]),
    .bin_i   (s2_tune_q),
    .quot_i  (quot),
    .rem_i   (rem),
    .start_i (start_q),
    .freq_o  (tune_f)
  );

  sspk_freq #(
    .NUM_BINS (NUM_BINS)
  ) u_best_freq (
    .clk_i   (clk_i),
    .en_i    (rdy[4:2]),
    .bin_i   (s2_q.best_bin),
    .quot_i  (quot),
    .rem_i   (rem),
    .start_i (start_q),
    .freq_o  (best_f)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s2_q      <= s1_item;
      s2_tune_q <= s1_tune;
    end
    if (rdy[2]) begin
      s3_q <= s2_q;
    end
    if (rdy[3]) begin
      s4_q <= s3_q;
    end
    if (rdy[4]) begin
      s5_q <= s4_q;
    end
    if (out_rdy) begin
      out_q    <= s5_q;
      tune_f_q <= tune_f;
      best_f_q <= best_f;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bin_index_o    = sspk_pkg::bin_out_t'(out_q.bin);
  assign level_o        = out_q.level;
  assign peak_level_o   = out_q.peak;
  assign tune_freq_hz_o = tune_f_q;
  assign sweep_end_o    = out_q.sweep_end;
  assign best_bin_o     = sspk_pkg::bin_out_t'(out_q.best_bin);
  assign best_level_o   = out_q.best_level;
  assign best_freq_hz_o = best_f_q;

endmodule

@@ design/sspk_ram.sv @@
module sspk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 48,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/sspk_span_div.sv @@
module sspk_span_div #(
  parameter int unsigned NUM_BINS = 48,
  localparam int unsigned BIN_W = $clog2(NUM_BINS)
) (
  input  logic                  clk_i,
  input  sspk_pkg::freq_t       start_i,
  input  sspk_pkg::freq_t       stop_i,
  output sspk_pkg::freq_t       quot_o,
  output logic [BIN_W-1:0]      rem_o
);

  localparam int unsigned FW = sspk_pkg::FREQ_W;
  localparam int unsigned DIV = NUM_BINS - 1;
  localparam logic [FW-1:0] DIV_F = FW'(DIV);
  localparam logic [FW:0] RECIP = (FW + 1)'((64'd1 << FW) / DIV);

  sspk_pkg::freq_t span_q;
  sspk_pkg::freq_t span2_q;
  sspk_pkg::freq_t qe_q;
  sspk_pkg::freq_t quot_q;
  logic [BIN_W-1:0] rem_q;
  logic [2*FW:0] prod;
  sspk_pkg::freq_t rmd;
  logic corr;

  assign prod = span_q * RECIP;
  assign rmd  = span2_q - FW'(qe_q * DIV_F);
  assign corr = (rmd >= DIV_F);

  always_ff @(posedge clk_i) begin
    span_q  <= (stop_i >= start_i) ? (stop_i - start_i) : '0;
    span2_q <= span_q;
    qe_q    <= FW'(prod >> FW);
    quot_q  <= corr ? (qe_q + 1'b1) : qe_q;
    rem_q   <= BIN_W'(corr ? (rmd - DIV_F) : rmd);
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ design/sspk_freq.sv @@
module sspk_freq #(
  parameter int unsigned NUM_BINS = 48,
  localparam int unsigned BIN_W = $clog2(NUM_BINS)
) (
  input  logic               clk_i,
  input  logic [2:0]         en_i,
  input  logic [BIN_W-1:0]   bin_i,
  input  sspk_pkg::freq_t    quot_i,
  input  logic [BIN_W-1:0]   rem_i,
  input  sspk_pkg::freq_t    start_i,
  output sspk_pkg::freq_t    freq_o
);

  localparam int unsigned FW = sspk_pkg::FREQ_W;
  localparam int unsigned TW = 2 * BIN_W;
  localparam int unsigned DIV = NUM_BINS - 1;
  localparam logic [TW-1:0] DIV_T = TW'(DIV);
  localparam logic [TW:0] RECIP = (TW + 1)'((64'd1 << TW) / DIV);

  sspk_pkg::freq_t a1_q;
  sspk_pkg::freq_t a2_q;
  sspk_pkg::freq_t a3_q;
  logic [TW-1:0] t1_q;
  logic [TW-1:0] t2_q;
  logic [BIN_W-1:0] qe_q;
  logic [BIN_W-1:0] qc_q;
  logic [2*TW:0] prod;
  logic [TW-1:0] rmd;

  assign prod = t1_q * RECIP;
  assign rmd  = t2_q - TW'(qe_q) * DIV_T;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a1_q <= FW'(quot_i * bin_i);
      t1_q <= TW'(rem_i) * TW'(bin_i);
    end
    if (en_i[1]) begin
      a2_q <= a1_q;
      t2_q <= t1_q;
      qe_q <= BIN_W'(prod >> TW);
    end
    if (en_i[2]) begin
      a3_q <= a2_q;
      qc_q <= (rmd >= DIV_T) ? BIN_W'(qe_q + 1'b1) : qe_q;
    end
  end

  assign freq_o = FW'(start_i + a3_q + FW'(qc_q));

endmodule

@@ design/sspk_peak.sv @@
module sspk_peak #(
  parameter int unsigned NUM_BINS = 48,
  localparam int unsigned BIN_W = $clog2(NUM_BINS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 kind_i,
  input  sspk_pkg::reading_t   reading_dbm_i,
  input  logic                 fire_i,
  input  sspk_pkg::level_t     level_floor_i,
  input  sspk_pkg::level_t     level_ceil_i,
  output logic [BIN_W-1:0]     bin_o,
  output sspk_pkg::level_t     level_o,
  output sspk_pkg::level_t     peak_o,
  output logic                 sweep_end_o,
  output logic [BIN_W-1:0]     best_bin_o,
  output sspk_pkg::level_t     best_level_o,
  output logic [BIN_W-1:0]     tune_bin_o
);

  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  logic [BIN_W-1:0]    bin_cnt_q;
  logic [NUM_BINS-1:0] pk_valid_q;
  sspk_pkg::level_t    clear_floor_q;
  logic [BIN_W-1:0]    best_bin_q;
  logic [BIN_W-1:0]    best_bin_d;
  sspk_pkg::level_t    best_pk_q;
  sspk_pkg::level_t    best_pk_d;

  logic                s1_kind_q;
  sspk_pkg::reading_t  s1_reading_q;
  logic [BIN_W-1:0]    s1_bin_q;

  logic [sspk_pkg::LEVEL_W-1:0] rd_data;
  sspk_pkg::reading_t  floor_x;
  sspk_pkg::reading_t  ceil_x;
  sspk_pkg::level_t    old_pk;
  sspk_pkg::level_t    lvl;
  sspk_pkg::level_t    new_pk;
  logic                last;
  logic                is_clear;

  sspk_ram #(
    .WIDTH (sspk_pkg::LEVEL_W),
    .DEPTH (NUM_BINS)
  ) u_peak_ram (
    .clk_i   (clk_i),
    .we_i    (fire_i && !is_clear),
    .waddr_i (s1_bin_q),
    .wdata_i (new_pk),
    .re_i    (accept_i),
    .raddr_i (bin_cnt_q),
    .rdata_o (rd_data)
  );

  assign is_clear = (s1_kind_q == sspk_pkg::KIND_CLEAR);
  assign floor_x  = {{8{level_floor_i[7]}}, level_floor_i};
  assign ceil_x   = {{8{level_ceil_i[7]}}, level_ceil_i};
  assign last     = (s1_bin_q == LAST_BIN);

  always_comb begin
    old_pk = pk_valid_q[s1_bin_q] ? sspk_pkg::level_t'(rd_data) : clear_floor_q;
    if (s1_reading_q < floor_x) begin
      lvl = level_floor_i;
    end else if (s1_reading_q > ceil_x) begin
      lvl = level_ceil_i;
    end else begin
      lvl = sspk_pkg::level_t'(s1_reading_q[7:0]);
    end
    new_pk = (lvl > old_pk) ? lvl : old_pk;
  end

  always_comb begin
    best_bin_d = best_bin_q;
    best_pk_d  = best_pk_q;
    if (is_clear) begin
      bin_o       = '0;
      level_o     = level_floor_i;
      peak_o      = level_floor_i;
      sweep_end_o = 1'b0;
      tune_bin_o  = '0;
      best_bin_d  = '0;
      best_pk_d   = level_floor_i;
    end else begin
      bin_o       = s1_bin_q;
      level_o     = lvl;
      peak_o      = new_pk;
      sweep_end_o = last;
      tune_bin_o  = last ? '0 : BIN_W'(s1_bin_q + 1'b1);
      if (s1_bin_q == '0) begin
        best_bin_d = '0;
        best_pk_d  = new_pk;
      end else if (new_pk > best_pk_q) begin
        best_bin_d = s1_bin_q;
        best_pk_d  = new_pk;
      end
    end
  end

  assign best_bin_o   = best_bin_d;
  assign best_level_o = best_pk_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_cnt_q     <= '0;
      pk_valid_q    <= '0;
      clear_floor_q <= sspk_pkg::LEVEL_FLOOR_RST;
      best_bin_q    <= '0;
      best_pk_q     <= sspk_pkg::LEVEL_FLOOR_RST;
    end else begin
      if (accept_i) begin
        if (kind_i == sspk_pkg::KIND_CLEAR || bin_cnt_q == LAST_BIN) begin
          bin_cnt_q <= '0;
        end else begin
          bin_cnt_q <= BIN_W'(bin_cnt_q + 1'b1);
        end
      end
      if (fire_i) begin
        best_bin_q <= best_bin_d;
        best_pk_q  <= best_pk_d;
        if (is_clear) begin
          pk_valid_q    <= '0;
          clear_floor_q <= level_floor_i;
        end else begin
          pk_valid_q[s1_bin_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_kind_q    <= kind_i;
      s1_reading_q <= reading_dbm_i;
      s1_bin_q     <= bin_cnt_q;
    end
  end

endmodule

@@ bench/tb_spectrum_sweep_peak_hold_unit.sv @@
module tb_spectrum_sweep_peak_hold_unit;

  localparam int NUM_BINS = 48;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    sspk_pkg::bin_out_t bin;
    sspk_pkg::level_t   lvl;
    sspk_pkg::level_t   peak;
    sspk_pkg::freq_t    tune;
    logic               last;
    sspk_pkg::bin_out_t lead;
    sspk_pkg::level_t   lead_lvl;
    sspk_pkg::freq_t    lead_freq;
  } peak_report_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [29:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               kind_i;
  sspk_pkg::reading_t reading_dbm_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  sspk_pkg::bin_out_t bin_index_o;
  sspk_pkg::level_t   level_o;
  sspk_pkg::level_t   peak_level_o;
  sspk_pkg::freq_t    tune_freq_hz_o;
  logic               sweep_end_o;
  sspk_pkg::bin_out_t best_bin_o;
  sspk_pkg::level_t   best_level_o;
  sspk_pkg::freq_t    best_freq_hz_o;

  spectrum_sweep_peak_hold_unit #(
    .NUM_BINS(NUM_BINS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .reading_dbm_i (reading_dbm_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bin_index_o   (bin_index_o),
    .level_o       (level_o),
    .peak_level_o  (peak_level_o),
    .tune_freq_hz_o(tune_freq_hz_o),
    .sweep_end_o   (sweep_end_o),
    .best_bin_o    (best_bin_o),
    .best_level_o  (best_level_o),
    .best_freq_hz_o(best_freq_hz_o)
  );

  always #6 clk_i = ~clk_i;

  sspk_pkg::freq_t  start_hz;
  sspk_pkg::freq_t  stop_hz;
  sspk_pkg::level_t floor_lvl;
  sspk_pkg::level_t ceil_lvl;
  int               peak_mem [NUM_BINS];
  int unsigned      sweep_bin;
  int unsigned      lead_bin;
  int               lead_peak;
  peak_report_t     peak_reports[$];

  int  err_count = 0;
  int  cycle_count = 0;
  bit  src_idle_en = 1'b1;
  bit  sink_idle_en = 1'b1;
  int  sink_gap_left = 0;
  int  sink_hold_left = 0;

  function automatic sspk_pkg::freq_t step_hz(int unsigned bin);
    longint unsigned lo, hi, width_hz;
    lo = start_hz;
    hi = stop_hz;
    width_hz = (hi >= lo) ? hi - lo : 0;
    return sspk_pkg::freq_t'(lo + width_hz * bin / (NUM_BINS - 1));
  endfunction

  function automatic void restart_sweep();
    for (int i = 0; i < NUM_BINS; i++) begin
      peak_mem[i] = floor_lvl;
    end
    sweep_bin = 0;
    lead_bin = 0;
    lead_peak = floor_lvl;
  endfunction

  task automatic hold_peak(logic kind, sspk_pkg::reading_t reading);
    peak_report_t r;
    int unsigned  cur;
    int           raw;
    int           clamped;
    if (kind == sspk_pkg::KIND_CLEAR) begin
      restart_sweep();
      r.bin = '0;
      r.lvl = floor_lvl;
      r.peak = floor_lvl;
      r.tune = step_hz(0);
      r.last = 1'b0;
      r.lead = '0;
      r.lead_lvl = floor_lvl;
      r.lead_freq = step_hz(0);
    end else begin
      cur = (sweep_bin >= NUM_BINS) ? 0 : sweep_bin;
      raw = reading;
      if (raw < floor_lvl) begin
        clamped = floor_lvl;
      end else if (raw > ceil_lvl) begin
        clamped = ceil_lvl;
      end else begin
        clamped = raw;
      end
      if (clamped > peak_mem[cur]) begin
        peak_mem[cur] = clamped;
      end
      if (cur == 0) begin
        lead_bin = 0;
        lead_peak = peak_mem[0];
      end else if (peak_mem[cur] > lead_peak) begin
        lead_bin = cur;
        lead_peak = peak_mem[cur];
      end
      r.last = (cur == NUM_BINS - 1);
      sweep_bin = r.last ? 0 : cur + 1;
      r.bin = sspk_pkg::bin_out_t'(cur);
      r.lvl = sspk_pkg::level_t'(clamped);
      r.peak = sspk_pkg::level_t'(peak_mem[cur]);
      r.tune = step_hz(sweep_bin);
      r.lead = sspk_pkg::bin_out_t'(lead_bin);
      r.lead_lvl = sspk_pkg::level_t'(lead_peak);
      r.lead_freq = step_hz(lead_bin);
    end
    peak_reports.push_back(r);
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    peak_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (peak_reports.size() == 0) begin
        $display("%0t: result transfer with no expected value, actual bin %0d level %0d",
                 $time, bin_index_o, level_o);
        err_count++;
      end else begin
        want = peak_reports.pop_front();
        check_field("bin_index", want.bin, bin_index_o);
        check_field("level", want.lvl, level_o);
        check_field("peak_level", want.peak, peak_level_o);
        check_field("tune_freq_hz", want.tune, tune_freq_hz_o);
        check_field("sweep_end", want.last, sweep_end_o);
        check_field("best_bin", want.lead, best_bin_o);
        check_field("best_level", want.lead_lvl, best_level_o);
        check_field("best_freq_hz", want.lead_freq, best_freq_hz_o);
      end
      sink_gap_left = sink_idle_en ? $urandom_range(0, 11) : 0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_hold_left > 0) begin
        out_ready_i = 1'b0;
        sink_hold_left--;
      end else if (sink_gap_left > 0) begin
        out_ready_i = 1'b0;
        sink_gap_left--;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, peak_reports.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The send task returns at the falling edge that follows its transfer, with valid still high,
  // so the caller either sends the next item at once or lowers valid.
  task automatic send_item(logic kind, sspk_pkg::reading_t reading);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    kind_i = kind;
    reading_dbm_i = reading;
    do @(posedge clk_i); while (!in_ready_o);
    hold_peak(kind, reading);
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    idle_input();
    while (peak_reports.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(sspk_pkg::cfg_idx_e idx, logic [29:0] value);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sspk_pkg::CFG_SPAN_START:  start_hz = value;
      sspk_pkg::CFG_SPAN_STOP:   stop_hz = value;
      sspk_pkg::CFG_LEVEL_FLOOR: floor_lvl = sspk_pkg::level_t'(value[7:0]);
      sspk_pkg::CFG_LEVEL_CEIL:  ceil_lvl = sspk_pkg::level_t'(value[7:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_level(sspk_pkg::cfg_idx_e idx, int lvl);
    logic [29:0] noise;
    noise = 30'($urandom);
    write_reg(idx, {noise[29:8], 8'(lvl)});
  endtask

  function automatic sspk_pkg::reading_t pick_reading();
    int v;
    case ($urandom_range(0, 9))
      0, 1: v = $signed(16'($urandom));
      2: begin
        v = $urandom_range(0, 6);
        v = v - 3 + floor_lvl;
      end
      3: begin
        v = $urandom_range(0, 6);
        v = v - 3 + ceil_lvl;
      end
      default: begin
        v = $urandom_range(0, 300);
        v = v - 160;
      end
    endcase
    return sspk_pkg::reading_t'(v);
  endfunction

  task automatic pick_settings();
    sspk_pkg::freq_t lo_hz, hi_hz;
    int              f, c, t;
    lo_hz = sspk_pkg::freq_t'($urandom);
    case ($urandom_range(0, 4))
      0: hi_hz = lo_hz + sspk_pkg::freq_t'($urandom_range(0, 5000));
      1: hi_hz = sspk_pkg::freq_t'($urandom);
      2: hi_hz = lo_hz;
      3: hi_hz = lo_hz - sspk_pkg::freq_t'($urandom_range(1, 1000));
      default: hi_hz = lo_hz + sspk_pkg::freq_t'($urandom_range(0, 50000000));
    endcase
    f = $urandom_range(0, 255);
    f -= 128;
    c = $urandom_range(0, 255);
    c -= 128;
    if (f > c && $urandom_range(0, 3) != 0) begin
      t = f;
      f = c;
      c = t;
    end
    if ($urandom_range(0, 3) != 0) write_reg(sspk_pkg::CFG_SPAN_START, lo_hz);
    if ($urandom_range(0, 3) != 0) write_reg(sspk_pkg::CFG_SPAN_STOP, hi_hz);
    if ($urandom_range(0, 3) != 0) write_level(sspk_pkg::CFG_LEVEL_FLOOR, f);
    if ($urandom_range(0, 3) != 0) write_level(sspk_pkg::CFG_LEVEL_CEIL, c);
  endtask

  task automatic test_level_extremes();
    send_item(sspk_pkg::KIND_SAMPLE, 16'sh7FFF);
    send_item(sspk_pkg::KIND_SAMPLE, -16'sh8000);
    send_item(sspk_pkg::KIND_SAMPLE, -16'sd20);
    send_item(sspk_pkg::KIND_SAMPLE, -16'sd19);
    send_item(sspk_pkg::KIND_SAMPLE, -16'sd120);
    send_item(sspk_pkg::KIND_SAMPLE, -16'sd121);
    send_item(sspk_pkg::KIND_SAMPLE, 16'sd0);
    send_item(sspk_pkg::KIND_CLEAR, 16'sh7FFF);
    send_item(sspk_pkg::KIND_SAMPLE, -16'sd50);
    send_item(sspk_pkg::KIND_SAMPLE, -16'sd60);
    send_item(sspk_pkg::KIND_SAMPLE, -16'sd40);
    send_item(sspk_pkg::KIND_CLEAR, -16'sh8000);
  endtask

  task automatic test_span_settings();
    write_reg(sspk_pkg::CFG_SPAN_START, 30'd0);
    write_reg(sspk_pkg::CFG_SPAN_STOP, 30'h3FFFFFFF);
    write_level(sspk_pkg::CFG_LEVEL_FLOOR, -128);
    write_level(sspk_pkg::CFG_LEVEL_CEIL, 127);
    send_item(sspk_pkg::KIND_SAMPLE, 16'sd127);
    send_item(sspk_pkg::KIND_SAMPLE, -16'sd128);
    send_item(sspk_pkg::KIND_SAMPLE, 16'sh7FFF);
    send_item(sspk_pkg::KIND_SAMPLE, -16'sh8000);
    // The span runs backwards and the floor sits above the ceiling.
    write_reg(sspk_pkg::CFG_SPAN_START, 30'h3FFFFFFF);
    write_reg(sspk_pkg::CFG_SPAN_STOP, 30'd0);
    write_level(sspk_pkg::CFG_LEVEL_FLOOR, 127);
    write_level(sspk_pkg::CFG_LEVEL_CEIL, -128);
    send_item(sspk_pkg::KIND_SAMPLE, -16'sh8000);
    send_item(sspk_pkg::KIND_SAMPLE, 16'sd0);
    send_item(sspk_pkg::KIND_SAMPLE, 16'sd127);
    send_item(sspk_pkg::KIND_SAMPLE, 16'sh7FFF);
    send_item(sspk_pkg::KIND_CLEAR, 16'sd5);
  endtask

  task automatic test_random_sweeps();
    for (int phase = 0; phase < 8; phase++) begin
      pick_settings();
      src_idle_en = $urandom_range(0, 3) != 0;
      sink_idle_en = $urandom_range(0, 3) != 0;
      for (int n = 0; n < 70; n++) begin
        send_item(($urandom_range(0, 39) == 0) ? sspk_pkg::KIND_CLEAR : sspk_pkg::KIND_SAMPLE,
                  pick_reading());
      end
    end
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_back_to_back();
    wait_drained();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    for (int n = 0; n < 60; n++) begin
      send_item(($urandom_range(0, 29) == 0) ? sspk_pkg::KIND_CLEAR : sspk_pkg::KIND_SAMPLE,
                pick_reading());
    end
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_output_stall();
    idle_input();
    @(posedge clk_i);
    sink_hold_left = 150;
    @(negedge clk_i);
    src_idle_en = 1'b0;
    for (int n = 0; n < 30; n++) begin
      send_item(sspk_pkg::KIND_SAMPLE, pick_reading());
    end
    src_idle_en = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = sspk_pkg::CFG_SPAN_START;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    kind_i = sspk_pkg::KIND_SAMPLE;
    reading_dbm_i = '0;
    start_hz = sspk_pkg::SPAN_START_RST;
    stop_hz = sspk_pkg::SPAN_STOP_RST;
    floor_lvl = sspk_pkg::LEVEL_FLOOR_RST;
    ceil_lvl = sspk_pkg::LEVEL_CEIL_RST;
    restart_sweep();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_level_extremes();
    test_span_settings();
    test_random_sweeps();
    test_back_to_back();
    test_output_stall();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
